[hw/rtl/plwu_pkg.sv]
// Shared types, constants and controller codes for the packed pixel LCD writer.
package plwu_pkg;

    // Panel defaults
    localparam int PanelColumnsDef = 240;
    localparam int PanelRowsDef    = 128;

    // Field widths
    localparam int ColW   = 8;
    localparam int RowW   = 7;
    localparam int LevelW = 5;
    localparam int ByteW  = 8;

    // Address arithmetic width: row * columns + member column stays below 2**16
    localparam int CalcW = 16;

    // Column / 3 by reciprocal: (col * 171) >> 9, exact for 8-bit columns
    localparam logic [CalcW-1:0] TRIPLE_RECIP = 16'd171;
    localparam int               TripleShift  = 9;
    localparam int               TripleW      = 7;

    // Controller codes sent to the panel
    localparam logic [ByteW-1:0] CMD_EXT_IN     = 8'h30;
    localparam logic [ByteW-1:0] CMD_COL_ADDR   = 8'h15;
    localparam logic [ByteW-1:0] COL_END_CODE   = 8'd79;
    localparam logic [ByteW-1:0] CMD_LINE_ADDR  = 8'h75;
    localparam logic [ByteW-1:0] LINE_END_CODE  = 8'd127;
    localparam logic [ByteW-1:0] CMD_MEM_WRITE  = 8'h5C;

    // Word positions within one pixel transaction sequence
    localparam logic [3:0] W_EXT_IN     = 4'd0;
    localparam logic [3:0] W_COL_CMD    = 4'd1;
    localparam logic [3:0] W_COL_START  = 4'd2;
    localparam logic [3:0] W_COL_END    = 4'd3;
    localparam logic [3:0] W_LINE_CMD   = 4'd4;
    localparam logic [3:0] W_LINE_START = 4'd5;
    localparam logic [3:0] W_LINE_END   = 4'd6;
    localparam logic [3:0] W_WRITE_CMD  = 4'd7;
    localparam logic [3:0] W_PIX0       = 4'd8;
    localparam logic [3:0] W_PIX1       = 4'd9;
    localparam logic [3:0] W_PIX2       = 4'd10;

    // Memory sequencer steps
    localparam logic [2:0] MS_IDLE  = 3'd0;
    localparam logic [2:0] MS_CALC  = 3'd1;
    localparam logic [2:0] MS_WRITE = 3'd2;
    localparam logic [2:0] MS_READ0 = 3'd3;
    localparam logic [2:0] MS_READ2 = 3'd5;
    localparam logic [2:0] MS_DONE  = 3'd6;

    typedef struct packed {
        logic [ColW-1:0]   column;
        logic [RowW-1:0]   row;
        logic [LevelW-1:0] grey_level;
    } t_in_item;

    typedef struct packed {
        logic             is_data;
        logic [ByteW-1:0] word_byte;
        logic             last_word;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       calc;
        logic       base_col;
        logic       wr_pixel;
        logic       clr_wr;
        logic       rd_issue;
        logic [1:0] rd_idx;
        logic       load;
        logic [3:0] word_idx;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

[hw/rtl/plwu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module plwu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/plwu_ctrl.sv]
// Controller state machine: clear pass, transaction intake and word sequencing.
module plwu_ctrl
    import plwu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_word, n_word;
    logic [2:0] r_mstep, n_mstep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_word  <= W_EXT_IN;
            r_mstep <= MS_IDLE;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_mstep <= n_mstep;
        end
    end

    // Next state and counters
    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        n_mstep = r_mstep;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                    n_word  = W_EXT_IN;
                    n_mstep = MS_CALC;
                end
            end
            ST_RUN: begin
                if (r_mstep != MS_DONE) begin
                    n_mstep = r_mstep + 3'd1;
                end
                if (i_sts.out_free) begin
                    n_word = r_word + 4'd1;
                    if (r_word == W_PIX2) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.word_idx = r_word;
        o_cmd.rd_idx   = 2'(r_mstep - MS_READ0);
        o_in_stall     = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_RUN: begin
                o_cmd.calc     = (r_mstep == MS_CALC);
                o_cmd.base_col = (r_mstep == MS_WRITE);
                o_cmd.wr_pixel = (r_mstep == MS_WRITE);
                o_cmd.rd_issue = r_mstep inside {[MS_READ0:MS_READ2]};
                o_cmd.load     = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

[hw/rtl/plwu_dp.sv]
// Datapath: shadow frame memory, address arithmetic, pixel fetch and output register.
module plwu_dp
    import plwu_pkg::*;
#(
    parameter int PANEL_COLUMNS = PanelColumnsDef,
    parameter int PANEL_ROWS    = PanelRowsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    output t_status   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int Depth = PANEL_COLUMNS * PANEL_ROWS;
    localparam int AddrW = $clog2(Depth);
    localparam logic [8:0]       COLS_LIM  = 9'(PANEL_COLUMNS);
    localparam logic [8:0]       ROWS_LIM  = 9'(PANEL_ROWS);
    localparam logic [CalcW-1:0] COLS_MULT = CalcW'(PANEL_COLUMNS);
    localparam logic [AddrW-1:0] LAST_ADDR = AddrW'(Depth - 1);

    logic [ColW-1:0]    r_col;
    logic [RowW-1:0]    r_row;
    logic [LevelW-1:0]  r_level;
    logic [CalcW-1:0]   r_row_base;
    logic [TripleW-1:0] r_triple;
    logic [ColW-1:0]    r_base_col;
    logic [AddrW-1:0]   r_clr_addr;
    logic               r_rd_pend;
    logic [1:0]         r_rd_idx;
    logic               r_rd_ok;
    logic [LevelW-1:0]  r_pix [3];
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CalcW-1:0]  triple_prod;
    logic [8:0]        mem_col;
    logic              row_ok;
    logic              wr_ok;
    logic              rd_ok;
    logic [CalcW-1:0]  wr_sum;
    logic [CalcW-1:0]  rd_sum;
    logic              mem_we;
    logic [AddrW-1:0]  mem_waddr;
    logic [LevelW-1:0] mem_wdata;
    logic [LevelW-1:0] mem_rdata;
    t_out_item         word;

    assign triple_prod = CalcW'(r_col) * TRIPLE_RECIP;
    assign mem_col     = {1'b0, r_base_col} + 9'(i_cmd.rd_idx);
    assign row_ok      = ({2'b0, r_row} < ROWS_LIM);
    assign wr_ok       = row_ok && ({1'b0, r_col} < COLS_LIM);
    assign rd_ok       = row_ok && (mem_col < COLS_LIM);
    assign wr_sum      = r_row_base + CalcW'(r_col);
    assign rd_sum      = r_row_base + CalcW'(mem_col);

    assign mem_we    = i_cmd.clr_wr || (i_cmd.wr_pixel && wr_ok);
    assign mem_waddr = i_cmd.clr_wr ? r_clr_addr : wr_sum[AddrW-1:0];
    assign mem_wdata = i_cmd.clr_wr ? '0 : r_level;

    plwu_ram #(
        .WIDTH(LevelW),
        .DEPTH(Depth)
    ) u_frame (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(rd_sum[AddrW-1:0]),
        .o_rdata(mem_rdata)
    );

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col   <= i_in.column;
            r_row   <= i_in.row;
            r_level <= i_in.grey_level;
        end
        if (i_cmd.calc) begin
            r_row_base <= CalcW'(r_row) * COLS_MULT;
            r_triple   <= triple_prod[TripleShift +: TripleW];
        end
        if (i_cmd.base_col) begin
            r_base_col <= {r_triple, 1'b0} + ColW'(r_triple);
        end
        if (i_cmd.rd_issue) begin
            r_rd_idx <= i_cmd.rd_idx;
            r_rd_ok  <= rd_ok;
        end
        if (r_rd_pend) begin
            r_pix[r_rd_idx] <= r_rd_ok ? mem_rdata : '0;
        end
        if (i_cmd.load) begin
            r_out <= word;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AddrW'(1);
            end
            r_rd_pend <= i_cmd.rd_issue;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Word select
    always_comb begin
        word = '0;
        case (i_cmd.word_idx)
            W_EXT_IN:     word.word_byte = CMD_EXT_IN;
            W_COL_CMD:    word.word_byte = CMD_COL_ADDR;
            W_COL_START: begin
                word.is_data   = 1'b1;
                word.word_byte = {1'b0, r_triple};
            end
            W_COL_END: begin
                word.is_data   = 1'b1;
                word.word_byte = COL_END_CODE;
            end
            W_LINE_CMD:   word.word_byte = CMD_LINE_ADDR;
            W_LINE_START: begin
                word.is_data   = 1'b1;
                word.word_byte = {1'b0, r_row};
            end
            W_LINE_END: begin
                word.is_data   = 1'b1;
                word.word_byte = LINE_END_CODE;
            end
            W_WRITE_CMD:  word.word_byte = CMD_MEM_WRITE;
            W_PIX0: begin
                word.is_data   = 1'b1;
                word.word_byte = {r_pix[0], 3'b000};
            end
            W_PIX1: begin
                word.is_data   = 1'b1;
                word.word_byte = {r_pix[1], 3'b000};
            end
            W_PIX2: begin
                word.is_data   = 1'b1;
                word.word_byte = {r_pix[2], 3'b000};
                word.last_word = 1'b1;
            end
            default: word = '0;
        endcase
    end

    assign o_sts.clr_last = (r_clr_addr == LAST_ADDR);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

endmodule

[hw/rtl/packed_pixel_lcd_writer_unit.sv]
// Top level of the packed pixel LCD writer: controller plus datapath.
//
// Input channel (i_in_valid / o_in_stall / i_in): one transaction is a pixel
// write of column, row and 5-bit grey level. The level is stored in a shadow
// frame memory (row-major, PANEL_COLUMNS x PANEL_ROWS) unless the pixel is
// off the panel.
// Output channel (o_out_valid / i_out_stall / o_out): eleven controller words
// per pixel: mode command, column address command with start/end, line
// address command with start/end, memory write command, then the three
// stored levels of the column triple shifted left by 3, the last one marked.
// After intake the controller moves to its run state and loads the first
// word into the output register once that register is free. The eleven
// words are then loaded one per cycle while the receiver does not stall;
// a stalled word holds the sequence, and each pixel is taken in the idle state.
// Input is taken only between pixels.
// Reset: the clearing pass writes zero into every frame entry, one per cycle,
// PANEL_COLUMNS * PANEL_ROWS entries in all (30720 by default); o_in_stall stays high
// until it completes. Stalled output words hold in the output register.
module packed_pixel_lcd_writer_unit
    import plwu_pkg::*;
#(
    parameter int PANEL_COLUMNS = PanelColumnsDef,
    parameter int PANEL_ROWS    = PanelRowsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_cmd    cmd;
    t_status sts;

    // Sequence clear pass, intake and word loads
    plwu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Hold the frame memory, compute addresses, fetch the triple, drive words
    plwu_dp #(
        .PANEL_COLUMNS(PANEL_COLUMNS),
        .PANEL_ROWS   (PANEL_ROWS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

endmodule

[dv/packed_pixel_lcd_writer_unit_tb.sv]
// Self-checking testbench for the packed pixel LCD writer: pixel writes in, controller words out.
module packed_pixel_lcd_writer_unit_tb;
    import plwu_pkg::*;

    // Flag values of the command/data bit
    localparam logic WORD_CMD  = 1'b0;
    localparam logic WORD_DATA = 1'b1;

    // Reset's clearing pass writes PanelColumnsDef * PanelRowsDef entries; the rest allows
    // roughly 130 pixels of eleven words each under heavy random stalling plus the long hold.
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_PIXELS = 112;
    localparam int HOLD_CYCLES   = 150;
    localparam int DIRECTED_N    = 18;

    // One directed pixel write; pix0..pix2 are typed-in data bytes when known is set.
    typedef struct packed {
        logic [ColW-1:0]   column;
        logic [RowW-1:0]   row;
        logic [LevelW-1:0] level;
        logic              known;
        logic [ByteW-1:0]  pix0;
        logic [ByteW-1:0]  pix1;
        logic [ByteW-1:0]  pix2;
    } t_pixel_case;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    // Predictor state: shadow copy of the frame and the words still owed by the block
    logic [LevelW-1:0] shadow_levels [PanelColumnsDef * PanelRowsDef];
    t_out_item         pending_words [$];

    int word_errors  = 0;
    int cycle_count  = 0;
    bit hold_request = 1'b0;   // raised by the sender to start the long receiver hold-off
    bit calm         = 1'b0;   // both sides stop idling while set

    // Directed table. Rows with known set carry the three pixel bytes read straight off the
    // sequence from a cleared frame; the others rely on the predictor.
    t_pixel_case directed_pixels [DIRECTED_N] = '{
        // First write after reset: only column 0 of the triple is lit
        '{8'd0,   7'd0,   5'd31, 1'b1, 8'hF8, 8'h00, 8'h00},
        // Write zero into the middle member: triple unchanged
        '{8'd1,   7'd0,   5'd0,  1'b1, 8'hF8, 8'h00, 8'h00},
        '{8'd2,   7'd0,   5'd16, 1'b1, 8'hF8, 8'h00, 8'h80},
        // Overwrite column 0 back to zero
        '{8'd0,   7'd0,   5'd0,  1'b1, 8'h00, 8'h00, 8'h80},
        // Last on-panel column and last row
        '{8'd239, 7'd127, 5'd31, 1'b1, 8'h00, 8'h00, 8'hF8},
        '{8'd238, 7'd127, 5'd1,  1'b1, 8'h00, 8'h08, 8'hF8},
        '{8'd237, 7'd127, 5'd31, 1'b1, 8'hF8, 8'h08, 8'hF8},
        // Off-panel columns: nothing stored, every triple member reads as zero
        '{8'd240, 7'd5,   5'd7,  1'b1, 8'h00, 8'h00, 8'h00},
        '{8'd255, 7'd127, 5'd31, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'd241, 7'd0,   5'd31, 1'b1, 8'h00, 8'h00, 8'h00},
        // Alternating bit patterns and neighbors within one triple
        '{8'd239, 7'd0,   5'd31, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd85,  7'd42,  5'd21, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd170, 7'd85,  5'd10, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd86,  7'd42,  5'd5,  1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd84,  7'd42,  5'd31, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd128, 7'd64,  5'd16, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd127, 7'd63,  5'd15, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'd3,   7'd1,   5'd1,  1'b0, 8'h00, 8'h00, 8'h00}
    };

    packed_pixel_lcd_writer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #10 i_clk = ~i_clk;

    function automatic void push_word(input logic is_data, input logic [ByteW-1:0] word_byte,
                                      input logic last_word);
        t_out_item w;
        w.is_data   = is_data;
        w.word_byte = word_byte;
        w.last_word = last_word;
        pending_words.push_back(w);
    endfunction

    // Store the new level in the shadow frame, then queue the eleven words the block owes.
    // When known is set, take the three pixel bytes from the table instead of the shadow.
    function automatic void queue_pixel_words(input t_in_item px, input logic known,
                                              input logic [ByteW-1:0] t0, t1, t2);
        int               col;
        int               row;
        int               triple_base;
        int               member;
        logic [ByteW-1:0] pix_byte;
        logic [ByteW-1:0] typed_byte [3];
        col           = int'(px.column);
        row           = int'(px.row);
        triple_base   = (col / 3) * 3;
        typed_byte[0] = t0;
        typed_byte[1] = t1;
        typed_byte[2] = t2;
        if (col < PanelColumnsDef && row < PanelRowsDef) begin
            shadow_levels[col + row * PanelColumnsDef] = px.grey_level;
        end
        push_word(WORD_CMD,  CMD_EXT_IN, 1'b0);
        push_word(WORD_CMD,  CMD_COL_ADDR, 1'b0);
        push_word(WORD_DATA, ByteW'(col / 3), 1'b0);
        push_word(WORD_DATA, COL_END_CODE, 1'b0);
        push_word(WORD_CMD,  CMD_LINE_ADDR, 1'b0);
        push_word(WORD_DATA, ByteW'(row), 1'b0);
        push_word(WORD_DATA, LINE_END_CODE, 1'b0);
        push_word(WORD_CMD,  CMD_MEM_WRITE, 1'b0);
        for (int i = 0; i < 3; i++) begin
            member = triple_base + i;
            // Off-panel triple members go out as zero
            if (member < PanelColumnsDef && row < PanelRowsDef) begin
                pix_byte = {shadow_levels[member + row * PanelColumnsDef], 3'b000};
            end else begin
                pix_byte = '0;
            end
            if (known) begin
                pix_byte = typed_byte[i];
            end
            push_word(WORD_DATA, pix_byte, i == 2);
        end
    endfunction

    // Offer one pixel write, idling first at random, and hold it until the block takes it.
    // Queue the expected words at the accepting edge, ahead of any output they cause.
    task automatic send_pixel(input t_in_item px, input logic known,
                              input logic [ByteW-1:0] t0, t1, t2);
        while (!calm && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= px;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        queue_pixel_words(px, known, t0, t1, t2);
    endtask

    // Sender: reset, directed table, then shaped random writes, then drain.
    initial begin : pixel_source
        t_in_item px;
        int       pick;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        for (int i = 0; i < PanelColumnsDef * PanelRowsDef; i++) begin
            shadow_levels[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; the clearing pass holds off the first one
        for (int i = 0; i < DIRECTED_N; i++) begin
            px.column     = directed_pixels[i].column;
            px.row        = directed_pixels[i].row;
            px.grey_level = directed_pixels[i].level;
            send_pixel(px, directed_pixels[i].known, directed_pixels[i].pix0,
                       directed_pixels[i].pix1, directed_pixels[i].pix2);
        end

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            // Start the long receiver hold-off early so the block backs up into the input
            if (n == 15) begin
                hold_request = 1'b1;
            end
            // Stretch with no idling on either side
            calm = (n >= 60 && n < 95);
            pick = $urandom_range(99);
            if (pick < 45) begin
                // Small window: revisit the same triples so reads return recent writes
                px.column = ColW'($urandom_range(11));
                px.row    = RowW'($urandom_range(3));
            end else if (pick < 85) begin
                px.column = ColW'($urandom_range(PanelColumnsDef - 1));
                px.row    = RowW'($urandom_range(PanelRowsDef - 1));
            end else begin
                // Off the panel on the right
                px.column = ColW'($urandom_range(255, PanelColumnsDef));
                px.row    = RowW'($urandom_range(127));
            end
            px.grey_level = LevelW'($urandom_range(31));
            send_pixel(px, 1'b0, '0, '0, '0);
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Drain, then give the block time to show any stray word
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);
        if (word_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver: random stalls, one long counted hold-off, no stalls while calm.
    initial begin : word_sink
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 29);
            end
        end
    end

    // Compare every accepted word with the oldest expectation, field by field.
    always @(posedge i_clk) begin : word_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: is_data=%0b word_byte=%02h last_word=%0b",
                       o_out.is_data, o_out.word_byte, o_out.last_word);
                word_errors++;
            end else begin
                want = pending_words.pop_front();
                if (o_out.is_data !== want.is_data) begin
                    $error("is_data: expected %0b, actual %0b", want.is_data, o_out.is_data);
                    word_errors++;
                end
                if (o_out.word_byte !== want.word_byte) begin
                    $error("word_byte: expected %02h, actual %02h",
                           want.word_byte, o_out.word_byte);
                    word_errors++;
                end
                if (o_out.last_word !== want.last_word) begin
                    $error("last_word: expected %0b, actual %0b",
                           want.last_word, o_out.last_word);
                    word_errors++;
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
